### rtl/ptm_pkg.sv
// ----------------------------------------------------------------------------
// ptm_pkg
// Shared constants, types and helpers for the page-table mapper with its
// page pool: geometry of the table store, result codes, entry bit positions.
// ----------------------------------------------------------------------------
package ptm_pkg;

   // Pool geometry
   localparam int POOL_PAGES       = 64;
   localparam int IDX_W            = 9;
   localparam int ENTRIES_PER_PAGE = 1 << IDX_W;
   localparam int PAGE_W           = $clog2(POOL_PAGES);
   localparam int STORE_AW         = PAGE_W + IDX_W;
   localparam int STORE_DEPTH      = POOL_PAGES * ENTRIES_PER_PAGE;
   localparam int NFP_W            = $clog2(POOL_PAGES + 1);

   // Field widths
   localparam int ENTRY_W  = 64;
   localparam int FRAME_W  = 40;
   localparam int VA_W     = 48;
   localparam int PA_W     = 52;
   localparam int VPN_W    = VA_W - 12;
   localparam int STATUS_W = 2;
   localparam int USED_W   = 7;

   // Configuration port
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 64;
   localparam logic CSR_REG_POOL_BASE = 1'b0;

   // Request modes
   localparam logic MODE_MAP    = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   // Result codes
   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS        = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OUT_OF_POOL = 2'd2;

   // Walk levels
   localparam logic [1:0] LVL_PML4 = 2'd0;
   localparam logic [1:0] LVL_PDPT = 2'd1;
   localparam logic [1:0] LVL_PD   = 2'd2;
   localparam logic [1:0] LVL_PT   = 2'd3;

   // Entry flag bits
   localparam int BIT_PRESENT = 0;
   localparam int BIT_LARGE   = 7;

   typedef enum logic [2:0] {
      ST_INIT,    // clearing pass after reset
      ST_IDLE,
      ST_READ,    // table read issued
      ST_EVAL,    // read data available
      ST_CLEAR,   // zeroing a newly taken page
      ST_LINK,    // writing the link to the new page
      ST_DONE     // result waiting for the output register
   } ptm_state_type;

   // Table store access, one write and one read port
   typedef struct packed {
      logic                we;
      logic [STORE_AW-1:0] waddr;
      logic [ENTRY_W-1:0]  wdata;
      logic                re;
      logic [STORE_AW-1:0] raddr;
   } ptm_ram_req_type;

   // 9-bit table index of a walk level
   function automatic logic [IDX_W-1:0] level_idx(input logic [VPN_W-1:0] vpn,
                                                  input logic [1:0] lvl);
      logic [IDX_W-1:0] idx;
      unique case (lvl)
         LVL_PML4: idx = vpn[35:27];
         LVL_PDPT: idx = vpn[26:18];
         LVL_PD:   idx = vpn[17:9];
         default:  idx = vpn[8:0];
      endcase
      return idx;
   endfunction

   // Set present and write, replace the frame field, keep the rest
   function automatic logic [ENTRY_W-1:0] set_link(input logic [ENTRY_W-1:0] old,
                                                  input logic [FRAME_W-1:0] frame);
      return {old[63:52], frame, old[11:2], 2'b11};
   endfunction

endpackage

### rtl/ptm_if.sv
// ----------------------------------------------------------------------------
// ptm_if
// Valid/ready channels of the mapper: request beats in, result beats out.
// ----------------------------------------------------------------------------
interface ptm_req_if
   import ptm_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              mode;
   logic [VA_W-1:0]   virt_addr;
   logic [PA_W-1:0]   target_phys_addr;

   modport source (output valid, output mode, output virt_addr,
                   output target_phys_addr, input ready);
   modport sink   (input valid, input mode, input virt_addr,
                   input target_phys_addr, output ready);
endinterface

interface ptm_rsp_if
   import ptm_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ENTRY_W-1:0]  leaf_entry;
   logic [USED_W-1:0]   pages_used;

   modport source (output valid, output status, output leaf_entry,
                   output pages_used, input ready);
   modport sink   (input valid, input status, input leaf_entry,
                   input pages_used, output ready);
endinterface

### rtl/ptm_table_ram.sv
// ----------------------------------------------------------------------------
// ptm_table_ram
// Table store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ptm_table_ram
   import ptm_pkg::*;
(
   input  logic                clock,
   input  ptm_ram_req_type     ram_req,
   output logic [ENTRY_W-1:0]  rd_data
);

   logic [ENTRY_W-1:0] mem [STORE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (ram_req.re) begin
         rd_data_ff <= mem[ram_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/page_table_map_with_pool_alloc.sv
// ----------------------------------------------------------------------------
// page_table_map_with_pool_alloc
// Four-level page-table map and lookup over a pool of table pages held in
// one synchronous table store.
// ----------------------------------------------------------------------------
//  channel   dir   beat fields                              handshake
//  req_chan  in    mode, virt_addr, target_phys_addr         valid/ready
//  rsp_chan  out   status, leaf_entry, pages_used            valid/ready
//  csr_*     in    pool_base_frame at 0x0                    APB, pready high
//
//  Each level issues a table read (ST_READ) and evaluates the registered
//  read data (ST_EVAL); a map with a zero target reads nothing. A map
//  adds one link write per page taken, and first clears the taken page
//  when it was written since. After reset a clearing pass zeroes the
//  whole store; req_ready stays low meanwhile, csr writes are taken.
//  A new request is taken while a result still waits in the output register;
//  a finished walk holds in its final state until that register frees.
// ----------------------------------------------------------------------------
module page_table_map_with_pool_alloc
   import ptm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   ptm_req_if.sink            req_chan,
   ptm_rsp_if.source          rsp_chan,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [CSR_AW-1:0]  csr_paddr,
   input  logic [CSR_DW-1:0]  csr_pwdata,
   output logic [CSR_DW-1:0]  csr_prdata,
   output logic               csr_pready
);

   ptm_state_type state_ff, state_in;

   logic [FRAME_W-1:0]   pool_base_ff;
   logic [NFP_W-1:0]     next_free_ff;
   logic [POOL_PAGES-1:0] dirty_ff;      // page written since last cleared
   logic [STORE_AW-1:0]  clr_ff;

   logic                 mode_ff;
   logic [VPN_W-1:0]     vpn_ff;
   logic [FRAME_W-1:0]   pa_frame_ff;
   logic [1:0]           lvl_ff;
   logic [PAGE_W-1:0]    page_ff;
   logic [STATUS_W-1:0]  res_status_ff;
   logic [ENTRY_W-1:0]   res_leaf_ff;

   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [ENTRY_W-1:0]   rsp_leaf_ff;
   logic [USED_W-1:0]    rsp_used_ff;

   ptm_ram_req_type      ram_req;
   logic [ENTRY_W-1:0]   rd_data;

   ptm_table_ram u_table_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   // ------------------------------------------------------------------
   // configuration port
   logic csr_wr;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_AW-1] == CSR_REG_POOL_BASE) ?
                       CSR_DW'(pool_base_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff <= '0;
      end else if (csr_wr && csr_paddr[CSR_AW-1] == CSR_REG_POOL_BASE) begin
         pool_base_ff <= csr_pwdata[FRAME_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // walk decode
   logic                 req_take;
   logic                 zero_target;
   logic                 out_free;
   logic [IDX_W-1:0]     cur_idx;
   logic [STORE_AW-1:0]  slot_addr;
   logic [PAGE_W-1:0]    new_page;
   logic                 pool_empty;
   logic [FRAME_W-1:0]   rel_frame;
   logic                 in_pool;
   logic                 present;
   logic                 lookup_leaf;
   logic [ENTRY_W-1:0]   leaf_new;
   logic [ENTRY_W-1:0]   link_old;
   logic [ENTRY_W-1:0]   link_new;
   logic                 clr_page_end;
   logic                 clr_all_end;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid & req_chan.ready;
   assign zero_target    = (req_chan.target_phys_addr == '0);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign cur_idx    = level_idx(vpn_ff, lvl_ff);
   assign slot_addr  = {page_ff, cur_idx};
   assign new_page   = next_free_ff[PAGE_W-1:0];
   assign pool_empty = (next_free_ff >= NFP_W'(POOL_PAGES));
   assign rel_frame  = rd_data[51:12] - pool_base_ff;
   assign in_pool    = (rel_frame < FRAME_W'(POOL_PAGES));
   assign present    = rd_data[BIT_PRESENT];
   assign lookup_leaf = (lvl_ff == LVL_PT) ||
                        ((lvl_ff == LVL_PDPT || lvl_ff == LVL_PD) && rd_data[BIT_LARGE]);
   assign leaf_new   = set_link(rd_data, pa_frame_ff);
   // the new page was just cleared if the slot sits in it
   assign link_old   = (page_ff == new_page) ? '0 : rd_data;
   assign link_new   = set_link(link_old, pool_base_ff + FRAME_W'(next_free_ff));

   assign clr_page_end = (clr_ff[IDX_W-1:0] == '1);
   assign clr_all_end  = (clr_ff == '1);

   // ------------------------------------------------------------------
   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (clr_all_end) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_take) begin
               if (req_chan.mode == MODE_MAP && zero_target) state_in = ST_DONE;
               else                                          state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_EVAL;
         ST_EVAL: begin
            if (mode_ff == MODE_MAP) begin
               if (lvl_ff == LVL_PT)       state_in = ST_DONE;
               else if (present)           state_in = in_pool ? ST_READ : ST_DONE;
               else if (pool_empty)        state_in = ST_DONE;
               else if (dirty_ff[new_page]) state_in = ST_CLEAR;
               else                        state_in = ST_LINK;
            end else begin
               if (!present || lookup_leaf || !in_pool) state_in = ST_DONE;
               else                                    state_in = ST_READ;
            end
         end
         ST_CLEAR: begin
            if (clr_page_end) state_in = ST_LINK;
         end
         ST_LINK: state_in = ST_READ;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase
   end

   // ------------------------------------------------------------------
   // table store access per state
   always_comb begin
      ram_req = '0;
      unique case (state_ff)
         ST_INIT: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = clr_ff;
         end
         ST_READ: begin
            ram_req.re    = 1'b1;
            ram_req.raddr = slot_addr;
         end
         ST_EVAL: begin
            if (mode_ff == MODE_MAP && lvl_ff == LVL_PT) begin
               ram_req.we    = 1'b1;
               ram_req.waddr = slot_addr;
               ram_req.wdata = leaf_new;
            end
         end
         ST_CLEAR: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = {new_page, clr_ff[IDX_W-1:0]};
         end
         ST_LINK: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = slot_addr;
            ram_req.wdata = link_new;
         end
         default: ram_req = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         next_free_ff <= NFP_W'(1);
         dirty_ff     <= '0;
         clr_ff       <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_INIT: clr_ff <= clr_ff + STORE_AW'(1);
            ST_EVAL: begin
               if (mode_ff == MODE_MAP && lvl_ff == LVL_PT) dirty_ff[page_ff] <= 1'b1;
            end
            ST_CLEAR: begin
               if (clr_page_end) begin
                  clr_ff             <= '0;
                  dirty_ff[new_page] <= 1'b0;
               end else begin
                  clr_ff <= clr_ff + STORE_AW'(1);
               end
            end
            ST_LINK: begin
               dirty_ff[page_ff] <= 1'b1;
               next_free_ff      <= next_free_ff + NFP_W'(1);
            end
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // walk datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               mode_ff       <= req_chan.mode;
               vpn_ff        <= req_chan.virt_addr[VA_W-1:12];
               pa_frame_ff   <= req_chan.target_phys_addr[PA_W-1:12];
               lvl_ff        <= LVL_PML4;
               page_ff       <= '0;
               res_status_ff <= STATUS_MISS;
               res_leaf_ff   <= '0;
            end
         end
         ST_EVAL: begin
            res_status_ff <= STATUS_MISS;
            res_leaf_ff   <= '0;
            if (mode_ff == MODE_MAP) begin
               if (lvl_ff == LVL_PT) begin
                  res_status_ff <= STATUS_OK;
                  res_leaf_ff   <= leaf_new;
               end else if (present) begin
                  page_ff <= rel_frame[PAGE_W-1:0];
                  lvl_ff  <= lvl_ff + 2'd1;
               end else if (pool_empty) begin
                  res_status_ff <= STATUS_OUT_OF_POOL;
               end
            end else begin
               if (present && lookup_leaf) begin
                  res_status_ff <= STATUS_OK;
                  res_leaf_ff   <= rd_data;
               end else if (present) begin
                  page_ff <= rel_frame[PAGE_W-1:0];
                  lvl_ff  <= lvl_ff + 2'd1;
               end
            end
         end
         ST_LINK: begin
            page_ff <= new_page;
            lvl_ff  <= lvl_ff + 2'd1;
         end
         default: ;
      endcase
   end

   // ------------------------------------------------------------------
   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_leaf_ff   <= res_leaf_ff;
         rsp_used_ff   <= USED_W'(next_free_ff);
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.leaf_entry = rsp_leaf_ff;
   assign rsp_chan.pages_used = rsp_used_ff;

endmodule

### rtl/ptm_checker.sv
// ----------------------------------------------------------------------------
// ptm_checker
// Port-level checks on the result channel of the mapper, bound to the top.
// ----------------------------------------------------------------------------
module ptm_checker
   import ptm_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [ENTRY_W-1:0]  rsp_leaf_entry,
   input logic [USED_W-1:0]   rsp_pages_used
);

   // a stalled result beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // only the three result codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_MISS ||
                     rsp_status == STATUS_OUT_OF_POOL))
      else $error("undefined result code");

   // the PML4 is always counted, never more than the pool
   a_pages_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pages_used >= USED_W'(1) &&
                     rsp_pages_used <= USED_W'(POOL_PAGES)))
      else $error("pages_used outside the pool");

   // a successful beat carries a present entry
   a_ok_present: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK |-> rsp_leaf_entry[BIT_PRESENT])
      else $error("success with absent leaf");

   // failures carry no entry
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_leaf_entry == '0)
      else $error("failure with non-zero leaf");

endmodule

bind page_table_map_with_pool_alloc ptm_checker u_ptm_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_status     (rsp_chan.status),
   .rsp_leaf_entry (rsp_chan.leaf_entry),
   .rsp_pages_used (rsp_chan.pages_used)
);

### bench/tb_page_table_map_with_pool_alloc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_table_map_with_pool_alloc
// Drives map and lookup requests into the page-table mapper and checks every
// result beat against a shadow copy of the table store and page pool. The
// pool base is moved between phases so that links wrap, alias other pool
// pages and fall outside the pool. The last phase runs the pool dry.
// ----------------------------------------------------------------------------
module tb_page_table_map_with_pool_alloc;
   import ptm_pkg::*;

   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int DRAIN_CYCLES = 16;
   localparam logic [ENTRY_W-1:0] FRAME_FIELD    = 64'h000F_FFFF_FFFF_F000;
   localparam logic [FRAME_W-1:0] BASE_TOP       = '1;
   localparam logic [CSR_AW-1:0]  POOL_BASE_ADDR = CSR_AW'(CSR_REG_POOL_BASE) << 3;

   typedef struct packed {
      logic              mode;
      logic [VA_W-1:0]   virt_addr;
      logic [PA_W-1:0]   target_phys_addr;
   } walk_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ENTRY_W-1:0]  leaf_entry;
      logic [USED_W-1:0]   pages_used;
   } walk_rsp_type;

   logic clock = 1'b0;
   logic reset;

   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [CSR_AW-1:0]  csr_paddr;
   logic [CSR_DW-1:0]  csr_pwdata;
   logic [CSR_DW-1:0]  csr_prdata;
   logic               csr_pready;

   ptm_req_if req_bus ();
   ptm_rsp_if rsp_bus ();

   page_table_map_with_pool_alloc dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the table store, the pool allocator and the base register
   bit   [ENTRY_W-1:0] table_copy [STORE_DEPTH];
   int unsigned        free_page = 1;
   logic [FRAME_W-1:0] pool_base = '0;

   walk_req_type    pending_reqs [$];
   walk_rsp_type    results_due [$];
   logic [VA_W-1:0] mapped_vas [$];

   int  req_count = 0;
   int  map_count = 0;
   int  lookup_count = 0;
   int  ok_count = 0;
   int  miss_count = 0;
   int  dry_count = 0;
   int  failures = 0;
   int  cycle_count = 0;

   // one long stretch where neither side idles
   wire steady = (req_count >= 600) && (req_count < 800);

   // ------------------------------------------------------------------------
   // Table walk shadow
   // ------------------------------------------------------------------------
   function automatic int unsigned va_index(input logic [VA_W-1:0] va, input int lvl);
      return 32'(va[12 + IDX_W * (int'(LVL_PT) - lvl) +: IDX_W]);
   endfunction

   // frame field replaced, present and write set, other bits kept
   function automatic logic [ENTRY_W-1:0] with_link(input logic [ENTRY_W-1:0] old,
                                                    input logic [FRAME_W-1:0] frame);
      return (old & ~FRAME_FIELD) | ENTRY_W'(3) | (ENTRY_W'(frame) << 12);
   endfunction

   // pool page an entry points at; frame arithmetic wraps at 40 bits
   function automatic bit points_into_pool(input logic [ENTRY_W-1:0] e,
                                           output int unsigned page);
      logic [FRAME_W-1:0] rel;
      rel  = e[51:12] - pool_base;
      page = 32'(rel[PAGE_W-1:0]);
      return rel < POOL_PAGES;
   endfunction

   function automatic walk_rsp_type walk_page_tables(input walk_req_type rq);
      walk_rsp_type       r;
      int unsigned        page;
      int unsigned        at;
      logic [ENTRY_W-1:0] e;
      bit                 done;
      r    = '0;
      page = 0;
      done = 1'b0;
      if (rq.mode == MODE_LOOKUP) begin
         // a large page at PDPT or PD ends the walk early
         for (int lvl = LVL_PML4; lvl <= LVL_PT && !done; lvl++) begin
            e = table_copy[page * ENTRIES_PER_PAGE + va_index(rq.virt_addr, lvl)];
            if (!e[BIT_PRESENT]) begin
               r.status = STATUS_MISS;
               done = 1'b1;
            end else if (lvl == LVL_PT || (lvl != LVL_PML4 && e[BIT_LARGE])) begin
               r.status     = STATUS_OK;
               r.leaf_entry = e;
               done = 1'b1;
            end else if (!points_into_pool(e, page)) begin
               r.status = STATUS_MISS;
               done = 1'b1;
            end
         end
      end else if (rq.target_phys_addr == '0) begin
         r.status = STATUS_MISS;
      end else begin
         // links taken on the way stay written if the walk stops later
         for (int lvl = LVL_PML4; lvl < LVL_PT && !done; lvl++) begin
            at = page * ENTRIES_PER_PAGE + va_index(rq.virt_addr, lvl);
            e  = table_copy[at];
            if (e[BIT_PRESENT]) begin
               if (!points_into_pool(e, page)) begin
                  r.status = STATUS_MISS;
                  done = 1'b1;
               end
            end else if (free_page >= POOL_PAGES) begin
               r.status = STATUS_OUT_OF_POOL;
               done = 1'b1;
            end else begin
               // the slot may sit in the page just cleared
               for (int i = 0; i < ENTRIES_PER_PAGE; i++)
                  table_copy[free_page * ENTRIES_PER_PAGE + i] = '0;
               table_copy[at] = with_link(table_copy[at], pool_base + FRAME_W'(free_page));
               page = free_page;
               free_page++;
            end
         end
         if (!done) begin
            at = page * ENTRIES_PER_PAGE + va_index(rq.virt_addr, LVL_PT);
            table_copy[at] = with_link(table_copy[at], rq.target_phys_addr[PA_W-1:12]);
            r.status     = STATUS_OK;
            r.leaf_entry = table_copy[at];
         end
      end
      r.pages_used = USED_W'(free_page);
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : drive_req
      walk_req_type item;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= 36)) begin
            item = pending_reqs.pop_front();
            req_bus.valid            <= 1'b1;
            req_bus.mode             <= item.mode;
            req_bus.virt_addr        <= item.virt_addr;
            req_bus.target_phys_addr <= item.target_phys_addr;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result backpressure
   always @(posedge clock) begin : drive_rsp_ready
      rsp_bus.ready <= !reset && (steady || $urandom_range(99) >= 36);
   end

   // ------------------------------------------------------------------------
   // Monitor: check result beats, then predict for the accepted request
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      walk_rsp_type exp;
      walk_req_type rq;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (results_due.size() == 0) begin
               $error("result beat with nothing outstanding: status %0d leaf %h",
                      rsp_bus.status, rsp_bus.leaf_entry);
               failures++;
            end else begin
               exp = results_due.pop_front();
               if (rsp_bus.status !== exp.status) begin
                  $error("status: expected %0d, got %0d", exp.status, rsp_bus.status);
                  failures++;
               end
               if (rsp_bus.leaf_entry !== exp.leaf_entry) begin
                  $error("leaf_entry: expected %h, got %h",
                         exp.leaf_entry, rsp_bus.leaf_entry);
                  failures++;
               end
               if (rsp_bus.pages_used !== exp.pages_used) begin
                  $error("pages_used: expected %0d, got %0d",
                         exp.pages_used, rsp_bus.pages_used);
                  failures++;
               end
               case (exp.status)
                  STATUS_OK:   ok_count++;
                  STATUS_MISS: miss_count++;
                  default:     dry_count++;
               endcase
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            rq.mode             = req_bus.mode;
            rq.virt_addr        = req_bus.virt_addr;
            rq.target_phys_addr = req_bus.target_phys_addr;
            results_due.push_back(walk_page_tables(rq));
            req_count++;
            if (rq.mode == MODE_MAP) map_count++;
            else lookup_count++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("page_table_map_with_pool_alloc test failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic logic [VA_W-1:0] make_va(input logic [8:0] i4, input logic [8:0] i3,
                                               input logic [8:0] i2, input logic [8:0] i1,
                                               input logic [11:0] offs);
      return {i4, i3, i2, i1, offs};
   endfunction

   function automatic logic [PA_W-1:0] rand_pa();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[PA_W-1:0];
   endfunction

   // addresses packed into a few table paths so the pool lasts
   function automatic logic [VA_W-1:0] region_va(input bit fresh_roots);
      logic [8:0] i4;
      logic [8:0] i3;
      logic [8:0] i2;
      i4 = fresh_roots ? 9'($urandom()) : ($urandom_range(1) ? 9'h1ff : 9'h000);
      case ($urandom_range(2))
         0:       i3 = 9'h000;
         1:       i3 = 9'h1ff;
         default: i3 = 9'h155;
      endcase
      i2 = $urandom_range(1) ? 9'h1ff : 9'h000;
      return make_va(i4, i3, i2, 9'($urandom()), 12'($urandom()));
   endfunction

   task automatic queue_item(input logic mode, input logic [VA_W-1:0] va,
                             input logic [PA_W-1:0] pa);
      pending_reqs.push_back('{mode, va, pa});
      if (mode == MODE_MAP && pa != '0) mapped_vas.push_back(va);
   endtask

   task automatic queue_random_phase(input int count, input bit fresh_roots);
      int unsigned     pick;
      logic [VA_W-1:0] known;
      repeat (count) begin
         pick  = $urandom_range(99);
         known = mapped_vas[$urandom_range(mapped_vas.size() - 1)];
         known[11:0] = 12'($urandom());
         if (pick < 40)
            queue_item(MODE_LOOKUP, known, rand_pa());
         else if (pick < 50)
            queue_item(MODE_LOOKUP, region_va(fresh_roots), rand_pa());
         else if (pick < 54)
            queue_item(MODE_MAP, region_va(fresh_roots), '0);
         else if (pick < 64)
            queue_item(MODE_MAP, known, rand_pa());
         else
            queue_item(MODE_MAP, region_va(fresh_roots), rand_pa());
      end
   endtask

   // APB write: setup beat, then access beat taken while pready is high
   task automatic set_pool_base(input logic [FRAME_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= POOL_BASE_ADDR;
      csr_pwdata  <= {24'($urandom()), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      pool_base = value;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || results_due.size() != 0 || req_bus.valid);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin : run_test
      logic [FRAME_W-1:0] mid_base;
      reset                    = 1'b1;
      csr_psel                 = 1'b0;
      csr_penable              = 1'b0;
      csr_pwrite               = 1'b0;
      csr_paddr                = '0;
      csr_pwdata               = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // base at the top: pool frames wrap through zero
      set_pool_base(BASE_TOP);
      queue_item(MODE_LOOKUP, '0, rand_pa());                 // empty store
      queue_item(MODE_MAP, '0, '0);                           // zero target
      queue_item(MODE_MAP, '0, 52'hFFF);                      // frame zero, low bits set
      queue_item(MODE_LOOKUP, '0, '0);
      queue_item(MODE_LOOKUP, make_va(0, 0, 0, 1, 0), rand_pa());   // PT miss
      queue_item(MODE_LOOKUP, make_va(1, 0, 0, 0, 0), rand_pa());   // PML4 miss
      queue_item(MODE_LOOKUP, make_va(0, 1, 0, 0, 0), rand_pa());   // PDPT miss
      queue_item(MODE_LOOKUP, make_va(0, 0, 1, 0, 0), rand_pa());   // PD miss
      queue_item(MODE_MAP, '1, '1);
      queue_item(MODE_LOOKUP, '1, '1);
      queue_item(MODE_MAP, '0, rand_pa());                    // remap keeps the entry
      queue_item(MODE_MAP, make_va(0, 0, 0, 9'h1ff, 0), {1'b1, 51'b0});
      queue_item(MODE_LOOKUP, make_va(0, 0, 0, 9'h1ff, 12'hfff), '0);
      queue_item(MODE_MAP, make_va(9'h1ff, 0, 0, 0, 0), rand_pa());
      queue_random_phase(480, 1'b0);
      wait_idle();

      // base at zero: old links now alias other pool pages
      set_pool_base('0);
      queue_item(MODE_LOOKUP, '0, rand_pa());
      queue_item(MODE_LOOKUP, '1, rand_pa());
      queue_item(MODE_MAP, '0, rand_pa());
      queue_item(MODE_MAP, '1, rand_pa());
      queue_random_phase(200, 1'b0);
      wait_idle();

      // base far away: old links point outside the pool
      mid_base = {8'($urandom_range(255, 1)), 32'($urandom())};
      set_pool_base(mid_base);
      queue_item(MODE_LOOKUP, '0, rand_pa());
      queue_item(MODE_MAP, '0, rand_pa());
      queue_item(MODE_MAP, make_va(9'h123, 9'h0aa, 9'h055, 9'h100, 0), rand_pa());
      queue_item(MODE_LOOKUP, make_va(9'h123, 9'h0aa, 9'h055, 9'h100, 0), rand_pa());
      queue_random_phase(150, 1'b0);
      wait_idle();

      // original base back, then spread out until the pool runs dry
      set_pool_base(BASE_TOP);
      queue_random_phase(400, 1'b0);
      wait_idle();
      queue_random_phase(160, 1'b1);
      wait_idle();

      $display("Ran %0d map and %0d lookup beats across four pool base settings",
               map_count, lookup_count);
      $display("Results: %0d ok, %0d not found, %0d out of pool; %0d pool pages taken",
               ok_count, miss_count, dry_count, free_page);
      if (failures == 0) begin
         $display("page_table_map_with_pool_alloc test passed");
      end else begin
         $display("page_table_map_with_pool_alloc test failed");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/ptm_pkg.sv
rtl/ptm_if.sv
rtl/ptm_table_ram.sv
rtl/page_table_map_with_pool_alloc.sv
rtl/ptm_checker.sv
bench/tb_page_table_map_with_pool_alloc.sv
